// ----- rtl/mskh_pkg.sv -----
// ----------------------------------------------------------------------------
// mskh_pkg
// Shared types and constants for the merge-split keep-low/keep-high block.
// ----------------------------------------------------------------------------
package mskh_pkg;

   localparam int unsigned VAL_W         = 32;
   localparam int unsigned MAX_BLOCK_DEF = 1024;

   // One input pair, tagged with the mode in force when it was taken in
   typedef struct packed {
      logic signed [VAL_W-1:0] own_value;
      logic signed [VAL_W-1:0] partner_value;
      logic                    last_pair;
      logic                    keep_high;
   } pair_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] merged_value;
      logic                    merged_last;
   } result_type;

   // Per-step control of one element queue
   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } fifo_ctl_type;

endpackage

// ----- rtl/mskh_front.sv -----
// ----------------------------------------------------------------------------
// mskh_front
// Input side: takes pairs into a two-deep queue and tags each with the mode.
// ----------------------------------------------------------------------------
module mskh_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic signed [mskh_pkg::VAL_W-1:0]    req_own_value,
   input  logic signed [mskh_pkg::VAL_W-1:0]    req_partner_value,
   input  logic                                 req_last_pair,
   input  logic                                 keep_high,
   output mskh_pkg::pair_type                   item,
   output logic                                 item_valid,
   input  logic                                 item_take
);
   import mskh_pkg::*;

   pair_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       enq, deq;

   assign req_full   = (cnt_ff == 2'd2);
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = q_ff[rd_ptr_ff];
   assign enq        = req_push && !req_full;
   assign deq        = item_take && item_valid;

   always_comb begin
      wr_ptr_in = enq ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = deq ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, enq} - {1'b0, deq};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         q_ff[wr_ptr_ff].own_value     <= req_own_value;
         q_ff[wr_ptr_ff].partner_value <= req_partner_value;
         q_ff[wr_ptr_ff].last_pair     <= req_last_pair;
         q_ff[wr_ptr_ff].keep_high     <= keep_high;
      end
   end

endmodule

// ----- rtl/mskh_fifo.sv -----
// ----------------------------------------------------------------------------
// mskh_fifo
// Element queue of one block: memory plus a three-entry head cache, so the
// head is ready every cycle even though the memory read is registered.
// ----------------------------------------------------------------------------
module mskh_fifo #(
   parameter int unsigned MAX_BLOCK = mskh_pkg::MAX_BLOCK_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mskh_pkg::fifo_ctl_type             ctl,
   input  logic signed [mskh_pkg::VAL_W-1:0]  push_value,
   output logic signed [mskh_pkg::VAL_W-1:0]  head_value
);
   import mskh_pkg::*;

   localparam int unsigned CNT_W   = $clog2(MAX_BLOCK + 1);
   localparam int unsigned PTR_W   = $clog2(MAX_BLOCK);
   localparam int unsigned CACHE_N = 3;

   logic [VAL_W-1:0]        mem [MAX_BLOCK];
   logic signed [VAL_W-1:0] cache_ff [CACHE_N];
   logic signed [VAL_W-1:0] cache_in [CACHE_N];
   logic signed [VAL_W-1:0] lst [CACHE_N+1];
   logic signed [VAL_W-1:0] rd_data_ff;
   logic [1:0]              ccnt_ff, ccnt_in;
   logic                    rd_vld_ff, rd_vld_in;
   logic [CNT_W-1:0]        mcnt_ff, mcnt_in;
   logic [CNT_W-1:0]        fill_ff, fill_in;
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic                    push_ok, direct, mem_wr, rd_issue;
   logic [2:0]              n_tot, n_keep;

   // Empty queue: the element pushed in this step is the head
   assign head_value = (ccnt_ff != 2'd0) ? cache_ff[0] : push_value;

   always_comb begin
      push_ok  = ctl.push && (fill_ff < CNT_W'(MAX_BLOCK));
      direct   = push_ok && (mcnt_ff == '0) && !rd_vld_ff
                 && ((ccnt_ff < 2'(CACHE_N)) || ctl.pop);
      mem_wr   = push_ok && !direct;

      // Ordered view: cache, then returning read, then direct push
      for (int i = 0; i < CACHE_N; i++) begin
         if (2'(i) < ccnt_ff) begin
            lst[i] = cache_ff[i];
         end else if (rd_vld_ff) begin
            lst[i] = rd_data_ff;
         end else begin
            lst[i] = push_value;
         end
      end
      lst[CACHE_N] = push_value;

      n_tot  = {1'b0, ccnt_ff} + {2'b0, rd_vld_ff} + {2'b0, direct};
      for (int i = 0; i < CACHE_N; i++) begin
         cache_in[i] = ctl.pop ? lst[i+1] : lst[i];
      end
      ccnt_in = 2'(n_tot - {2'b0, ctl.pop});

      // Refill while the cache after this step would have room
      n_keep   = {1'b0, ccnt_ff} + {2'b0, rd_vld_ff} - {2'b0, ctl.pop};
      rd_issue = (mcnt_ff != '0) && (n_keep <= 3'(CACHE_N - 1));
      rd_vld_in = rd_issue;

      mcnt_in = mcnt_ff + CNT_W'(mem_wr) - CNT_W'(rd_issue);
      fill_in = fill_ff + CNT_W'(push_ok) - CNT_W'(ctl.pop);

      wr_ptr_in = wr_ptr_ff;
      if (mem_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(MAX_BLOCK - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (rd_issue) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(MAX_BLOCK - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         ccnt_ff   <= 2'd0;
         rd_vld_ff <= 1'b0;
         mcnt_ff   <= '0;
         fill_ff   <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         ccnt_ff   <= ccnt_in;
         rd_vld_ff <= rd_vld_in;
         mcnt_ff   <= mcnt_in;
         fill_ff   <= fill_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CACHE_N; i++) begin
         cache_ff[i] <= cache_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem[wr_ptr_ff] <= push_value;
      end
      if (rd_issue) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

endmodule

// ----- rtl/mskh_back.sv -----
// ----------------------------------------------------------------------------
// mskh_back
// Merge engine: pushes each pair into the two element queues, compares the
// heads, pops the winner and queues the result for the consumer.
// ----------------------------------------------------------------------------
module mskh_back #(
   parameter int unsigned MAX_BLOCK = mskh_pkg::MAX_BLOCK_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mskh_pkg::pair_type                 item,
   input  logic                               item_valid,
   output logic                               item_take,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic signed [mskh_pkg::VAL_W-1:0]  rsp_merged_value,
   output logic                               rsp_merged_last
);
   import mskh_pkg::*;

   fifo_ctl_type            own_ctl, partner_ctl;
   logic signed [VAL_W-1:0] own_head, partner_head;
   logic                    fire, take_own;
   result_type              res;

   result_type              oq_ff [2];
   logic                    oq_wr_ff, oq_wr_in;
   logic                    oq_rd_ff, oq_rd_in;
   logic [1:0]              oq_cnt_ff, oq_cnt_in;
   logic                    oq_deq;

   mskh_fifo #(.MAX_BLOCK(MAX_BLOCK)) u_own_fifo (
      .clock      (clock),
      .reset      (reset),
      .ctl        (own_ctl),
      .push_value (item.own_value),
      .head_value (own_head)
   );

   mskh_fifo #(.MAX_BLOCK(MAX_BLOCK)) u_partner_fifo (
      .clock      (clock),
      .reset      (reset),
      .ctl        (partner_ctl),
      .push_value (item.partner_value),
      .head_value (partner_head)
   );

   // Advance one step whenever a pair waits and the result queue has room
   assign fire      = item_valid && (oq_cnt_ff != 2'd2);
   assign item_take = fire;

   always_comb begin
      // Ties go to the partner element
      if (item.keep_high) begin
         take_own = partner_head < own_head;
      end else begin
         take_own = own_head < partner_head;
      end

      own_ctl.push       = fire;
      own_ctl.pop        = fire && take_own;
      own_ctl.clear      = fire && item.last_pair;
      partner_ctl.push   = fire;
      partner_ctl.pop    = fire && !take_own;
      partner_ctl.clear  = fire && item.last_pair;

      res.merged_value = take_own ? own_head : partner_head;
      res.merged_last  = item.last_pair;
   end

   assign rsp_empty        = (oq_cnt_ff == 2'd0);
   assign rsp_merged_value = oq_ff[oq_rd_ff].merged_value;
   assign rsp_merged_last  = oq_ff[oq_rd_ff].merged_last;
   assign oq_deq           = rsp_pop && !rsp_empty;

   always_comb begin
      oq_wr_in  = fire ? ~oq_wr_ff : oq_wr_ff;
      oq_rd_in  = oq_deq ? ~oq_rd_ff : oq_rd_ff;
      oq_cnt_in = oq_cnt_ff + {1'b0, fire} - {1'b0, oq_deq};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff  <= 1'b0;
         oq_rd_ff  <= 1'b0;
         oq_cnt_ff <= 2'd0;
      end else begin
         oq_wr_ff  <= oq_wr_in;
         oq_rd_ff  <= oq_rd_in;
         oq_cnt_ff <= oq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         oq_ff[oq_wr_ff] <= res;
      end
   end

endmodule

// ----- rtl/merge_split_keep_low_or_high_top.sv -----
// ----------------------------------------------------------------------------
// merge_split_keep_low_or_high_top
// Merge-split step: keeps the low half ascending or the high half descending
// of two sorted blocks streamed in as pairs, one result per pair.
// ----------------------------------------------------------------------------
//   channel  handshake          payload
//   req      req_push/req_full  own_value, partner_value, last_pair
//   rsp      rsp_pop/rsp_empty  merged_value, merged_last
//   csr      csr_wen            csr_wdata (keep_high)
//
// One pair per cycle sustained while the consumer pops; a result is on
// the rsp ports in the cycle after its pair is taken. The rate is set by
// the head compare and pop of the two element queues, whose three-entry
// head caches hide the memory read. Reset clears all pointers and counts;
// no clearing pass is needed. A stalled consumer fills the two-deep result
// queue, then the two-deep input queue, after which req_full rises.
// ----------------------------------------------------------------------------
module merge_split_keep_low_or_high_top #(
   parameter int unsigned MAX_BLOCK = mskh_pkg::MAX_BLOCK_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic signed [mskh_pkg::VAL_W-1:0]  req_own_value,
   input  logic signed [mskh_pkg::VAL_W-1:0]  req_partner_value,
   input  logic                               req_last_pair,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic signed [mskh_pkg::VAL_W-1:0]  rsp_merged_value,
   output logic                               rsp_merged_last,
   input  logic                               csr_wen,
   input  logic                               csr_wdata
);
   import mskh_pkg::*;

   logic     keep_high_ff;
   pair_type item;
   logic     item_valid, item_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_high_ff <= 1'b0;
      end else if (csr_wen) begin
         keep_high_ff <= csr_wdata;
      end
   end

   mskh_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_own_value     (req_own_value),
      .req_partner_value (req_partner_value),
      .req_last_pair     (req_last_pair),
      .keep_high         (keep_high_ff),
      .item              (item),
      .item_valid        (item_valid),
      .item_take         (item_take)
   );

   mskh_back #(.MAX_BLOCK(MAX_BLOCK)) u_back (
      .clock            (clock),
      .reset            (reset),
      .item             (item),
      .item_valid       (item_valid),
      .item_take        (item_take),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_merged_value (rsp_merged_value),
      .rsp_merged_last  (rsp_merged_last)
   );

endmodule

// ----- tb/tb_merge_split_keep_low_or_high_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_merge_split_keep_low_or_high_top
// Drives pairs of sorted-block elements into the merge-split block and checks
// every merged beat against an in-bench merge predictor. The tests are:
// directed extremes and ties in both modes, a mode switch in mid-block, an
// overrun of the element queues, a long consumer stall, and random blocks.
// ----------------------------------------------------------------------------
module tb_merge_split_keep_low_or_high_top;
   import mskh_pkg::*;

   localparam int MAX_BLK      = MAX_BLOCK_DEF;
   localparam int PTR_W        = $clog2(MAX_BLK) + 1;
   localparam int RANDOM_ITEMS = 190;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 4;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PRINT_LIMIT  = 40;

   localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

   typedef enum int {SPREAD_FULL, SPREAD_NARROW, SPREAD_EDGE} spread_type;

   logic                    clock;
   logic                    reset             = 1'b1;
   logic                    req_push          = 1'b0;
   logic                    req_full;
   logic signed [VAL_W-1:0] req_own_value     = '0;
   logic signed [VAL_W-1:0] req_partner_value = '0;
   logic                    req_last_pair     = 1'b0;
   logic                    rsp_empty;
   logic                    rsp_pop           = 1'b0;
   logic signed [VAL_W-1:0] rsp_merged_value;
   logic                    rsp_merged_last;
   logic                    csr_wen           = 1'b0;
   logic                    csr_wdata         = 1'b0;

   merge_split_keep_low_or_high_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_own_value     (req_own_value),
      .req_partner_value (req_partner_value),
      .req_last_pair     (req_last_pair),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_merged_value  (rsp_merged_value),
      .rsp_merged_last   (rsp_merged_last),
      .csr_wen           (csr_wen),
      .csr_wdata         (csr_wdata)
   );

   // Merge predictor state
   logic signed [VAL_W-1:0] own_mem     [0:MAX_BLK-1];
   logic signed [VAL_W-1:0] partner_mem [0:MAX_BLK-1];
   logic [PTR_W-1:0]        own_rd      = '0;
   logic [PTR_W-1:0]        own_wr      = '0;
   logic [PTR_W-1:0]        partner_rd  = '0;
   logic [PTR_W-1:0]        partner_wr  = '0;
   bit                      keep_high_now = 1'b0;

   result_type merged_expect_q[$];
   int         error_count  = 0;
   int         cycle_count  = 0;
   bit         pace_gaps    = 1'b1;
   bit         hold_rsp_req = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("merge_split_keep_low_or_high_top test failed");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int rand_value(input spread_type spread);
      case (spread)
         SPREAD_FULL:   return $urandom;
         SPREAD_NARROW: return int'($urandom_range(0, 16)) - 8;
         default: begin
            case ($urandom_range(0, 5))
               0:       return VAL_MIN;
               1:       return VAL_MIN + 1;
               2:       return -1;
               3:       return 0;
               4:       return VAL_MAX - 1;
               default: return VAL_MAX;
            endcase
         end
      endcase
   endfunction

   // Push both elements, compare heads, pop the chosen one
   function automatic void predict_merge(input logic signed [VAL_W-1:0] own_v,
                                         input logic signed [VAL_W-1:0] partner_v,
                                         input logic last);
      logic [PTR_W-1:0]        own_fill;
      logic [PTR_W-1:0]        partner_fill;
      logic signed [VAL_W-1:0] own_top;
      logic signed [VAL_W-1:0] partner_top;
      bit                      take_own;
      result_type              r;
      own_fill     = own_wr - own_rd;
      partner_fill = partner_wr - partner_rd;
      // drop an element that arrives at a full queue
      if (own_fill < MAX_BLK) begin
         own_mem[own_wr[PTR_W-2:0]] = own_v;
         own_wr = own_wr + 1'b1;
      end
      if (partner_fill < MAX_BLK) begin
         partner_mem[partner_wr[PTR_W-2:0]] = partner_v;
         partner_wr = partner_wr + 1'b1;
      end
      own_top     = own_mem[own_rd[PTR_W-2:0]];
      partner_top = partner_mem[partner_rd[PTR_W-2:0]];
      // ties go to the partner in both modes
      take_own = keep_high_now ? (partner_top < own_top) : (own_top < partner_top);
      if (take_own) begin
         r.merged_value = own_top;
         own_rd = own_rd + 1'b1;
      end else begin
         r.merged_value = partner_top;
         partner_rd = partner_rd + 1'b1;
      end
      r.merged_last = last;
      if (last) begin
         own_rd     = '0;
         own_wr     = '0;
         partner_rd = '0;
         partner_wr = '0;
      end
      merged_expect_q.insert(merged_expect_q.size(), r);
   endfunction

   // Leaves req_push high on return so back-to-back beats need no toggle
   task automatic send_pair(input logic signed [VAL_W-1:0] own_v,
                            input logic signed [VAL_W-1:0] partner_v,
                            input logic last);
      int gap;
      gap = pace_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push          <= 1'b1;
      req_own_value     <= own_v;
      req_partner_value <= partner_v;
      req_last_pair     <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_merge(own_v, partner_v, last);
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      @(posedge clock);
      while (merged_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_mode(input bit mode);
      wait_drained();
      csr_wen   <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      keep_high_now = mode;
      csr_wen <= 1'b0;
   endtask

   // Result side pacing; a hold request stalls the consumer for a long stretch
   initial begin : rsp_pacing
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp_req) begin
            hold_rsp_req = 1'b0;
            stall_left   = HOLD_CYCLES;
         end else if (stall_left == 0 && pace_gaps && $urandom_range(0, 9) < 3) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_pop <= 1'b0;
            stall_left--;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : merge_check
      result_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (merged_expect_q.size() == 0) begin
            if (error_count < PRINT_LIMIT)
               $display("%0t: unexpected beat value=%0d last=%0b", $time,
                        rsp_merged_value, rsp_merged_last);
            error_count++;
         end else begin
            want = merged_expect_q.pop_front();
            if (rsp_merged_value !== want.merged_value) begin
               if (error_count < PRINT_LIMIT)
                  $display("%0t: merged_value expected %0d actual %0d", $time,
                           want.merged_value, rsp_merged_value);
               error_count++;
            end
            if (rsp_merged_last !== want.merged_last) begin
               if (error_count < PRINT_LIMIT)
                  $display("%0t: merged_last expected %0b actual %0b", $time,
                           want.merged_last, rsp_merged_last);
               error_count++;
            end
         end
      end
   end

   // Reset value of the mode first, then an explicit write of it
   task automatic test_keep_low_extremes();
      send_pair(VAL_MIN, VAL_MIN, 1'b0);
      send_pair(-5,      3,       1'b0);
      send_pair(0,       7,       1'b0);
      send_pair(7,       VAL_MAX, 1'b1);
      set_mode(1'b0);
      send_pair(VAL_MAX, VAL_MAX, 1'b1);
      send_pair(VAL_MIN, VAL_MAX, 1'b1);
      send_pair(VAL_MAX, VAL_MIN, 1'b1);
   endtask

   task automatic test_keep_high_extremes();
      set_mode(1'b1);
      send_pair(VAL_MAX, VAL_MAX, 1'b0);
      send_pair(9,       9,       1'b0);
      send_pair(-1,      -3,      1'b0);
      send_pair(VAL_MIN, VAL_MIN, 1'b1);
      send_pair(VAL_MIN, VAL_MIN, 1'b1);
      send_pair(VAL_MIN, VAL_MAX, 1'b1);
   endtask

   task automatic test_mode_switch_mid_block();
      set_mode(1'b0);
      send_pair(1, 2, 1'b0);
      send_pair(3, 4, 1'b0);
      set_mode(1'b1);
      send_pair(10, 8, 1'b0);
      send_pair(5,  5, 1'b1);
   endtask

   // Own side wins all but the last ten pairs, so the partner queue runs full and drops elements
   task automatic test_queue_overrun();
      set_mode(1'b0);
      for (int i = 0; i < MAX_BLK + 16; i++) begin
         if (i < MAX_BLK + 6)
            send_pair(-2000000000 + i * 3, 1000000 + i * 5, 1'b0);
         else
            send_pair(VAL_MAX, 1000000 + i * 5, i == MAX_BLK + 15);
      end
   endtask

   task automatic test_consumer_stall();
      set_mode(1'b0);
      pace_gaps    = 1'b0;
      hold_rsp_req = 1'b1;
      while (hold_rsp_req) @(posedge clock);
      for (int i = 0; i < 12; i++)
         send_pair(i * 4, i * 4 + 1, i == 11);
      pace_gaps = 1'b1;
   endtask

   // Mostly sorted blocks in the order of the mode, some unsorted noise
   task automatic test_random_blocks();
      int         sent;
      int         len;
      int         shape;
      spread_type spread;
      int         own_blk[$];
      int         partner_blk[$];
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0)
            set_mode(1'($urandom_range(0, 1)));
         pace_gaps = ($urandom_range(0, 3) != 0);
         shape = $urandom_range(0, 99);
         if (shape < 80)
            len = $urandom_range(1, 8);
         else if (shape < 96)
            len = $urandom_range(9, 64);
         else
            len = $urandom_range(65, 200);
         if (len > RANDOM_ITEMS - sent)
            len = RANDOM_ITEMS - sent;
         spread = spread_type'($urandom_range(0, 2));
         own_blk.delete();
         partner_blk.delete();
         repeat (len) begin
            own_blk.insert(own_blk.size(), rand_value(spread));
            partner_blk.insert(partner_blk.size(), rand_value(spread));
         end
         if ($urandom_range(0, 99) < 85) begin
            if (keep_high_now) begin
               own_blk.rsort();
               partner_blk.rsort();
            end else begin
               own_blk.sort();
               partner_blk.sort();
            end
         end
         for (int i = 0; i < len; i++)
            send_pair(own_blk[i], partner_blk[i], i == len - 1);
         sent += len;
      end
      pace_gaps = 1'b1;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_keep_low_extremes();
      test_keep_high_extremes();
      test_mode_switch_mid_block();
      test_queue_overrun();
      test_consumer_stall();
      test_random_blocks();
      wait_drained();
      if (error_count == 0 && merged_expect_q.size() == 0)
         $display("merge_split_keep_low_or_high_top test passed");
      else
         $display("merge_split_keep_low_or_high_top test failed");
      $finish;
   end

endmodule
